/* rtl/ils_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ils_pkg: shared types and constants of the indexed list store
// Command and status codes, stream field widths and offsets, and the
// operation bundle that the controller broadcasts to the cell row.
// ----------------------------------------------------------------------------
package ils_pkg;

    // Field widths of the request and the result
    localparam int CMD_W     = 4;
    localparam int POS_W     = 7;
    localparam int PAYLOAD_W = 64;
    localparam int STATUS_W  = 2;

    // Request tdata layout, lowest bit first
    localparam int S_CMD_LSB     = 0;
    localparam int S_POS_LSB     = S_CMD_LSB + CMD_W;
    localparam int S_PAYLOAD_LSB = S_POS_LSB + POS_W;
    localparam int S_USED_W      = S_PAYLOAD_LSB + PAYLOAD_W;
    localparam int S_TDATA_W     = ((S_USED_W + 7) / 8) * 8;

    // Result tdata layout, lowest bit first
    localparam int M_RD_LSB    = 0;
    localparam int M_ST_LSB    = M_RD_LSB + PAYLOAD_W;
    localparam int M_CNT_LSB   = M_ST_LSB + STATUS_W;
    localparam int M_USED_W    = M_CNT_LSB + POS_W;
    localparam int M_TDATA_W   = ((M_USED_W + 7) / 8) * 8;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_ADD_AT     = 4'd0;
    localparam logic [CMD_W-1:0] CMD_ADD_FIRST  = 4'd1;
    localparam logic [CMD_W-1:0] CMD_ADD_LAST   = 4'd2;
    localparam logic [CMD_W-1:0] CMD_REM_AT     = 4'd3;
    localparam logic [CMD_W-1:0] CMD_REM_FIRST  = 4'd4;
    localparam logic [CMD_W-1:0] CMD_REM_LAST   = 4'd5;
    localparam logic [CMD_W-1:0] CMD_GET_AT     = 4'd6;
    localparam logic [CMD_W-1:0] CMD_GET_FIRST  = 4'd7;
    localparam logic [CMD_W-1:0] CMD_GET_LAST   = 4'd8;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    // Operation broadcast to every cell
    typedef struct packed {
        logic ins;   // open a slot at the target and write the new word
        logic rem;   // close the slot at the target
        logic cap;   // capture the word held at the target
    } ils_op_t;

endpackage : ils_pkg
`default_nettype wire

/* rtl/ils_cell.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ils_cell: one slot of the shifting list
// Holds one word; on insert, cells above the target take the lower neighbor's
// word and the target the new word; on remove, the target and cells above take
// the upper neighbor's word; on a read the target slot captures its word.
// ----------------------------------------------------------------------------
module ils_cell #(
    parameter int DATA_WIDTH = 64,
    parameter int IDX_W      = 6,
    parameter int CELL_IDX   = 0
) (
    input  wire logic                  clk,
    input  wire ils_pkg::ils_op_t      op,
    input  wire logic [IDX_W-1:0]      target,
    input  wire logic [DATA_WIDTH-1:0] ins_word,
    input  wire logic [DATA_WIDTH-1:0] prev_word,
    input  wire logic [DATA_WIDTH-1:0] next_word,
    output logic      [DATA_WIDTH-1:0] word,
    output logic      [DATA_WIDTH-1:0] sel_word
);
    import ils_pkg::*;

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

    logic [DATA_WIDTH-1:0] word_reg;
    logic [DATA_WIDTH-1:0] word_next;
    logic [DATA_WIDTH-1:0] sel_reg;
    logic                  hit;
    logic                  above;

    assign hit   = (MY_IDX == target);
    assign above = (MY_IDX > target);

    // Shift up on insert, down on remove, hold otherwise
    always_comb
    begin
        word_next = word_reg;
        if (op.ins)
        begin
            if (above)
            begin
                word_next = prev_word;
            end
            else if (hit)
            begin
                word_next = ins_word;
            end
        end
        else if (op.rem && (above || hit))
        begin
            word_next = next_word;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    // Capture the target word; every other cell offers zero
    always_ff @(posedge clk)
    begin
        if (op.cap)
        begin
            sel_reg <= hit ? word_reg : '0;
        end
    end

    assign word     = word_reg;
    assign sel_word = sel_reg;

endmodule : ils_cell
`default_nettype wire

/* rtl/indexed_list_store.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// indexed_list_store: ordered list of data words with insert, remove, get
// A row of cells holds the list; inserts and removes shift the cells at and
// above the target at once, reads gather the target cell's word through an OR of the row.
// ----------------------------------------------------------------------------
//  Channel  Dir  Handshake           Contents
//  s_*      in   s_tvalid/s_tready   command, position, payload
//  m_*      out  m_tvalid/m_tready   read_data, status, entry_count
//
//  Each request passes through accept, execute (shift or capture in the
//  cell row), and gather (OR of the captured words into the result register).
//  s_tready is high only while no request is in progress; a pending result
//  does not block acceptance, but the gather step waits while the result
//  register is still full. Reset clears the count and control; the cell
//  words are not reset and are read only after being written.
// ----------------------------------------------------------------------------
module indexed_list_store #(
    parameter int CAPACITY   = 64,
    parameter int DATA_WIDTH = 64
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    // command [3:0], position [10:4], payload [74:11], zero fill above
    input  wire logic [ils_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    // read_data [63:0], status [65:64], entry_count [72:66], zero fill above
    output logic      [ils_pkg::M_TDATA_W-1:0] m_tdata
);
    import ils_pkg::*;

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_READ = 2'd2;

    localparam logic [CMP_W-1:0] CAP_EXT = CMP_W'(CAPACITY);

    logic [1:0]            state_reg;
    logic [1:0]            state_next;
    logic [CMD_W-1:0]      cmd_reg;
    logic [POS_W-1:0]      pos_reg;
    logic [DATA_WIDTH-1:0] payload_reg;
    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;
    logic [STATUS_W-1:0]   status_reg;
    logic                  get_reg;
    logic                  m_tvalid_reg;
    logic [DATA_WIDTH-1:0] rd_out_reg;
    logic [STATUS_W-1:0]   st_out_reg;
    logic [POS_W-1:0]      cnt_out_reg;

    logic                  accept;
    logic                  load_out;
    logic                  slot_free;

    logic [CMP_W-1:0]      pos_ext;
    logic [CMP_W-1:0]      cnt_ext;
    logic [CMP_W-1:0]      tpos;
    logic [STATUS_W-1:0]   status_c;
    logic                  is_get;
    ils_op_t               op;
    logic [DATA_WIDTH-1:0] gathered;

    logic [DATA_WIDTH-1:0] cell_word [CAPACITY];
    logic [DATA_WIDTH-1:0] sel_word  [CAPACITY];

    assign s_tready  = (state_reg == S_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign slot_free = !m_tvalid_reg || m_tready;
    assign load_out  = (state_reg == S_READ) && slot_free;

    assign pos_ext = CMP_W'(pos_reg);
    assign cnt_ext = CMP_W'(count_reg);

    // Decode the request against the current count
    always_comb
    begin
        tpos       = '0;
        status_c   = ST_RANGE;
        is_get     = 1'b0;
        op         = '0;
        count_next = count_reg;
        unique case (cmd_reg)
            CMD_ADD_AT, CMD_ADD_FIRST, CMD_ADD_LAST:
            begin
                unique case (cmd_reg)
                    CMD_ADD_AT:    tpos = pos_ext;
                    CMD_ADD_FIRST: tpos = '0;
                    default:       tpos = cnt_ext;
                endcase
                if (cnt_ext == CAP_EXT)
                begin
                    status_c = ST_FULL;
                end
                else if (tpos > cnt_ext)
                begin
                    status_c = ST_RANGE;
                end
                else
                begin
                    status_c   = ST_OK;
                    op.ins     = 1'b1;
                    count_next = count_reg + 1'b1;
                end
            end
            CMD_REM_AT, CMD_REM_FIRST, CMD_REM_LAST:
            begin
                unique case (cmd_reg)
                    CMD_REM_AT:    tpos = pos_ext;
                    CMD_REM_FIRST: tpos = '0;
                    default:       tpos = cnt_ext - 1'b1;
                endcase
                if (cnt_ext != '0 && tpos < cnt_ext)
                begin
                    status_c   = ST_OK;
                    op.rem     = 1'b1;
                    count_next = count_reg - 1'b1;
                end
            end
            CMD_GET_AT, CMD_GET_FIRST, CMD_GET_LAST:
            begin
                unique case (cmd_reg)
                    CMD_GET_AT:    tpos = pos_ext;
                    CMD_GET_FIRST: tpos = '0;
                    default:       tpos = cnt_ext - 1'b1;
                endcase
                is_get = 1'b1;
                op.cap = 1'b1;
                if (cnt_ext != '0 && tpos < cnt_ext)
                begin
                    status_c = ST_OK;
                end
            end
            default:
            begin
                status_c = ST_RANGE;
            end
        endcase
        if (state_reg != S_EXEC)
        begin
            op = '0;
        end
    end

    // Cell row
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [DATA_WIDTH-1:0] prev_w;
        logic [DATA_WIDTH-1:0] next_w;
        if (i == 0)
        begin : g_first
            assign prev_w = '0;
        end
        else
        begin : g_prev
            assign prev_w = cell_word[i-1];
        end
        if (i == CAPACITY - 1)
        begin : g_last
            assign next_w = '0;
        end
        else
        begin : g_next
            assign next_w = cell_word[i+1];
        end
        ils_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .IDX_W      (IDX_W),
            .CELL_IDX   (i)
        ) u_cell (
            .clk       (clk),
            .op        (op),
            .target    (tpos[IDX_W-1:0]),
            .ins_word  (payload_reg),
            .prev_word (prev_w),
            .next_word (next_w),
            .word      (cell_word[i]),
            .sel_word  (sel_word[i])
        );
    end

    // Gather the captured word; only the target cell offers nonzero data
    always_comb
    begin
        gathered = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            gathered = gathered | sel_word[i];
        end
    end

    // Sequence one request at a time
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (accept) state_next = S_EXEC;
            S_EXEC:  state_next = S_READ;
            S_READ:  if (slot_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_EXEC)
            begin
                count_reg <= count_next;
            end
        end
    end

    // Hold the request fields
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg     <= s_tdata[S_CMD_LSB +: CMD_W];
            pos_reg     <= s_tdata[S_POS_LSB +: POS_W];
            payload_reg <= s_tdata[S_PAYLOAD_LSB +: DATA_WIDTH];
        end
        if (state_reg == S_EXEC)
        begin
            status_reg <= status_c;
            get_reg    <= is_get;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            rd_out_reg  <= (get_reg && status_reg == ST_OK) ? gathered : '0;
            st_out_reg  <= status_reg;
            cnt_out_reg <= cnt_ext[POS_W-1:0];
        end
    end

    assign m_tvalid = m_tvalid_reg;

    always_comb
    begin
        m_tdata                          = '0;
        m_tdata[M_RD_LSB +: PAYLOAD_W]   = PAYLOAD_W'(rd_out_reg);
        m_tdata[M_ST_LSB +: STATUS_W]    = st_out_reg;
        m_tdata[M_CNT_LSB +: POS_W]      = cnt_out_reg;
    end

    // Count never passes the capacity
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

    // Execute always moves on to gather
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_EXEC |=> state_reg == S_READ)
    else $error("execute step did not advance");

    // A successful insert grows the list by one
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EXEC && op.ins) |=> count_reg == $past(count_reg) + 1'b1)
    else $error("insert did not grow the count");

    // A full list rejects any insert
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EXEC && count_reg == CNT_W'(CAPACITY)) |-> !op.ins)
    else $error("insert into a full list");

endmodule : indexed_list_store
`default_nettype wire
